// File: hdl/ascii_to_integer_parser_assert.svh
// Assertion macros shared by the text-to-integer parser RTL
`ifndef ASCII_TO_INTEGER_PARSER_ASSERT_SVH
`define ASCII_TO_INTEGER_PARSER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ATOI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("atoi same-cycle check failed");

// next-cycle implication, disabled during reset
`define ATOI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("atoi next-cycle check failed");

`endif

// File: hdl/atoi_pkg.sv
// Shared constants and types of the text-to-integer parser
package atoi_pkg;

   // value and count widths
   localparam int VALUE_BITS    = 64;
   localparam int COUNT_BITS    = 16;
   localparam int CHR_BITS      = 8;
   localparam int NUMBER_BITS   = 64;
   localparam int CONSUMED_BITS = 16;
   localparam int BASE_BITS     = 6;
   localparam int DIGIT_BITS    = 6;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 6;

   // limits of the value
   localparam logic [VALUE_BITS-1:0] VAL_MASK = {VALUE_BITS{1'b1}};
   localparam logic [VALUE_BITS-1:0] SMAX_VAL = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic [VALUE_BITS-1:0] SMIN_VAL = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_RADIX    = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_UNSIGNED = 1'd1;

   // character codes
   localparam logic [CHR_BITS-1:0] CHR_MINUS = 8'h2D;
   localparam logic [CHR_BITS-1:0] CHR_PLUS  = 8'h2B;
   localparam logic [CHR_BITS-1:0] CHR_ZERO  = 8'h30;
   localparam logic [CHR_BITS-1:0] CHR_NINE  = 8'h39;
   localparam logic [CHR_BITS-1:0] CHR_UX    = 8'h58;
   localparam logic [CHR_BITS-1:0] CHR_LX    = 8'h78;
   localparam logic [CHR_BITS-1:0] CHR_UA    = 8'h41;
   localparam logic [CHR_BITS-1:0] CHR_UZ    = 8'h5A;
   localparam logic [CHR_BITS-1:0] CHR_LA    = 8'h61;
   localparam logic [CHR_BITS-1:0] CHR_LZ    = 8'h7A;
   localparam logic [CHR_BITS-1:0] CHR_SPACE = 8'h20;
   localparam logic [CHR_BITS-1:0] CHR_TAB   = 8'h09;
   localparam logic [CHR_BITS-1:0] CHR_CR    = 8'h0D;

   // bases
   localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;

   // decoded character
   typedef struct packed {
      logic                  is_space;
      logic                  is_sign;
      logic                  is_minus;
      logic                  is_zero;
      logic                  is_x;
      logic                  is_digit;
      logic [DIGIT_BITS-1:0] digit;
   } char_class_type;

endpackage

// File: hdl/atoi_channels.sv
// Handshake channels of the text-to-integer parser

// character words in
interface atoi_req_if;
   logic                          valid;
   logic                          ready;
   logic [atoi_pkg::CHR_BITS-1:0] chr;
   logic                          first;

   modport source (output valid, output chr, output first, input ready);
   modport sink   (input valid, input chr, input first, output ready);
endinterface

// converted numbers out
interface atoi_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [atoi_pkg::NUMBER_BITS-1:0]   number;
   logic                               range_error;
   logic [atoi_pkg::CONSUMED_BITS-1:0] consumed;

   modport source (output valid, output number, output range_error, output consumed,
                   input ready);
   modport sink   (input valid, input number, input range_error, input consumed,
                   output ready);
endinterface

// File: hdl/atoi_classify.sv
// Character decoder: whitespace, sign, prefix and digit value
module atoi_classify (
   input  logic [atoi_pkg::CHR_BITS-1:0] chr,
   output atoi_pkg::char_class_type      cls
);

   logic [atoi_pkg::CHR_BITS-1:0] offs;

   // digit value from the matching letter or numeral range
   always_comb begin
      offs = '0;
      if (chr inside {[atoi_pkg::CHR_ZERO:atoi_pkg::CHR_NINE]}) begin
         offs = chr - atoi_pkg::CHR_ZERO;
      end else if (chr inside {[atoi_pkg::CHR_LA:atoi_pkg::CHR_LZ]}) begin
         offs = chr - atoi_pkg::CHR_LA + 8'd10;
      end else if (chr inside {[atoi_pkg::CHR_UA:atoi_pkg::CHR_UZ]}) begin
         offs = chr - atoi_pkg::CHR_UA + 8'd10;
      end
   end

   always_comb begin
      cls.is_space = (chr == atoi_pkg::CHR_SPACE) ||
                     (chr inside {[atoi_pkg::CHR_TAB:atoi_pkg::CHR_CR]});
      cls.is_minus = (chr == atoi_pkg::CHR_MINUS);
      cls.is_sign  = (chr == atoi_pkg::CHR_MINUS) || (chr == atoi_pkg::CHR_PLUS);
      cls.is_zero  = (chr == atoi_pkg::CHR_ZERO);
      cls.is_x     = (chr == atoi_pkg::CHR_LX) || (chr == atoi_pkg::CHR_UX);
      cls.is_digit = (chr inside {[atoi_pkg::CHR_ZERO:atoi_pkg::CHR_NINE]}) ||
                     (chr inside {[atoi_pkg::CHR_LA:atoi_pkg::CHR_LZ]}) ||
                     (chr inside {[atoi_pkg::CHR_UA:atoi_pkg::CHR_UZ]});
      cls.digit    = offs[atoi_pkg::DIGIT_BITS-1:0];
   end

endmodule

// File: hdl/atoi_mac.sv
// Multiply-add of the accumulator by the base with the range check
module atoi_mac (
   input  logic [atoi_pkg::VALUE_BITS-1:0] acc,
   input  logic [atoi_pkg::BASE_BITS-1:0]  base,
   input  logic [atoi_pkg::DIGIT_BITS-1:0] digit,
   input  logic                            unsigned_mode,
   input  logic                            negative,
   output logic [atoi_pkg::VALUE_BITS-1:0] acc_next,
   output logic                            over
);

   localparam int PROD_BITS = atoi_pkg::VALUE_BITS + atoi_pkg::BASE_BITS + 1;

   logic [atoi_pkg::VALUE_BITS-1:0] limit;
   logic [PROD_BITS-1:0]            wide;

   // magnitude limit: unsigned max, or signed max (one more when negative)
   always_comb begin
      if (unsigned_mode) begin
         limit = atoi_pkg::VAL_MASK;
      end else if (negative) begin
         limit = atoi_pkg::SMIN_VAL;
      end else begin
         limit = atoi_pkg::SMAX_VAL;
      end
   end

   // full-width product, so exceeding the limit is a plain compare
   assign wide     = PROD_BITS'(acc) * PROD_BITS'(base) + PROD_BITS'(digit);
   assign over     = (wide > PROD_BITS'(limit));
   assign acc_next = wide[atoi_pkg::VALUE_BITS-1:0];

endmodule

// File: hdl/ascii_to_integer_parser.sv
// Top level of the streaming text-to-integer parser
// The parser takes one character word per clock unless a stalled result holds
// it back. A character is held in an input register while the step logic
// (character decode, one 64 x 6 multiply-add of the accumulator by the base,
// and the range compare) updates the conversion state; the result for the
// character that terminates the number is registered in the output register
// and presented on rsp_bus. The multiply-add in that step stage sets the
// clock rate. A word with first set starts a new
// conversion; after a result further characters are ignored until the next
// first. The output register lets the next character be taken while a result
// waits; a stalled result only stops input once another terminating character
// is reached.
`include "ascii_to_integer_parser_assert.svh"

module ascii_to_integer_parser (
   input  logic                               clock,
   input  logic                               reset,
   atoi_req_if.sink                           req_bus,
   atoi_rsp_if.source                         rsp_bus,
   input  logic                               csr_wr_en,
   input  logic [atoi_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [atoi_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   // conversion phases
   localparam logic [2:0] PH_SPACE     = 3'd0;
   localparam logic [2:0] PH_PREFIX    = 3'd1;
   localparam logic [2:0] PH_ZERO_AUTO = 3'd2;
   localparam logic [2:0] PH_ZERO_HEX  = 3'd3;
   localparam logic [2:0] PH_DIGITS    = 3'd4;
   localparam logic [2:0] PH_DONE      = 3'd5;

   // configuration
   logic [atoi_pkg::BASE_BITS-1:0]  radix_ff, radix_in;
   logic                            unsigned_ff, unsigned_in;

   // input register
   logic                            in_valid_ff, in_valid_in;
   logic [atoi_pkg::CHR_BITS-1:0]   chr_ff;
   logic                            first_ff;

   // conversion state
   logic [2:0]                      phase_ff, phase_in;
   logic                            neg_ff, neg_in;
   logic [atoi_pkg::BASE_BITS-1:0]  base_ff, base_in;
   logic [atoi_pkg::VALUE_BITS-1:0] acc_ff, acc_in;
   logic                            ovf_ff, ovf_in;
   logic [atoi_pkg::COUNT_BITS-1:0] cnt_ff, cnt_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [atoi_pkg::VALUE_BITS-1:0] number_ff, number_in;
   logic                            range_ff;
   logic [atoi_pkg::COUNT_BITS-1:0] consumed_ff;

   // step logic
   atoi_pkg::char_class_type        cls;
   logic [2:0]                      pre_phase;
   logic                            pre_neg;
   logic [atoi_pkg::BASE_BITS-1:0]  pre_base;
   logic [atoi_pkg::VALUE_BITS-1:0] pre_acc;
   logic                            pre_ovf;
   logic [atoi_pkg::COUNT_BITS-1:0] pre_cnt;
   logic                            pre_inc;
   logic                            pre_stop;
   logic [atoi_pkg::VALUE_BITS-1:0] mac_acc;
   logic                            mac_over;
   logic                            take;
   logic                            emit;
   logic                            advance;
   logic                            out_free;
   logic                            accept;

   atoi_classify u_classify (
      .chr (chr_ff),
      .cls (cls)
   );

   atoi_mac u_mac (
      .acc           (pre_acc),
      .base          (pre_base),
      .digit         (cls.digit),
      .unsigned_mode (unsigned_ff),
      .negative      (pre_neg),
      .acc_next      (mac_acc),
      .over          (mac_over)
   );

   // configuration writes
   always_comb begin
      radix_in    = radix_ff;
      unsigned_in = unsigned_ff;
      if (csr_wr_en) begin
         case (csr_index)
            atoi_pkg::REG_RADIX:    radix_in    = csr_wdata;
            atoi_pkg::REG_UNSIGNED: unsigned_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // prefix handling: whitespace, sign, base selection and 0x
   always_comb begin
      pre_phase = first_ff ? PH_SPACE : phase_ff;
      pre_neg   = first_ff ? 1'b0 : neg_ff;
      pre_base  = first_ff ? atoi_pkg::BASE_AUTO : base_ff;
      pre_acc   = first_ff ? '0 : acc_ff;
      pre_ovf   = first_ff ? 1'b0 : ovf_ff;
      pre_cnt   = first_ff ? '0 : cnt_ff;
      pre_inc   = 1'b0;
      pre_stop  = 1'b0;

      if (pre_phase == PH_DONE) begin
         pre_stop = 1'b1;
      end

      if (!pre_stop && pre_phase == PH_SPACE) begin
         if (cls.is_space) begin
            pre_inc  = 1'b1;
            pre_stop = 1'b1;
         end else begin
            pre_phase = PH_PREFIX;
            if (cls.is_sign) begin
               pre_neg  = cls.is_minus;
               pre_inc  = 1'b1;
               pre_stop = 1'b1;
            end
         end
      end

      if (!pre_stop && pre_phase == PH_PREFIX) begin
         if (radix_ff == atoi_pkg::BASE_AUTO) begin
            if (cls.is_zero) begin
               pre_inc   = 1'b1;
               pre_phase = PH_ZERO_AUTO;
               pre_stop  = 1'b1;
            end else begin
               pre_base  = atoi_pkg::BASE_DEC;
               pre_phase = PH_DIGITS;
            end
         end else if (radix_ff == atoi_pkg::BASE_HEX && cls.is_zero) begin
            pre_base  = atoi_pkg::BASE_HEX;
            pre_acc   = '0;
            pre_inc   = 1'b1;
            pre_phase = PH_ZERO_HEX;
            pre_stop  = 1'b1;
         end else begin
            pre_base  = radix_ff;
            pre_phase = PH_DIGITS;
         end
      end

      if (!pre_stop && pre_phase == PH_ZERO_AUTO) begin
         pre_phase = PH_DIGITS;
         if (cls.is_x) begin
            pre_base = atoi_pkg::BASE_HEX;
            pre_inc  = 1'b1;
            pre_stop = 1'b1;
         end else begin
            pre_base = atoi_pkg::BASE_OCT;
         end
      end

      if (!pre_stop && pre_phase == PH_ZERO_HEX) begin
         pre_phase = PH_DIGITS;
         if (cls.is_x) begin
            pre_inc  = 1'b1;
            pre_stop = 1'b1;
         end
      end

      if (!pre_stop && pre_base == atoi_pkg::BASE_AUTO) begin
         pre_base = atoi_pkg::BASE_DEC;
      end
   end

   // digit accumulation or termination
   assign take = !pre_stop && cls.is_digit && (cls.digit < pre_base);
   assign emit = !pre_stop && !take;

   always_comb begin
      phase_in = pre_phase;
      acc_in   = pre_acc;
      ovf_in   = pre_ovf;
      if (take) begin
         phase_in = PH_DIGITS;
         acc_in   = mac_acc;
         ovf_in   = pre_ovf | mac_over;
      end else if (emit) begin
         phase_in = PH_DONE;
      end
      neg_in  = pre_neg;
      base_in = pre_base;
      cnt_in  = ((pre_inc || take) && pre_cnt != atoi_pkg::CNT_MAX) ?
                pre_cnt + 1'b1 : pre_cnt;
   end

   // final value: saturated on overflow, otherwise the magnitude, negated in two's complement when negative
   always_comb begin
      if (pre_ovf) begin
         if (unsigned_ff) begin
            number_in = atoi_pkg::VAL_MASK;
         end else if (pre_neg) begin
            number_in = atoi_pkg::SMIN_VAL;
         end else begin
            number_in = atoi_pkg::SMAX_VAL;
         end
      end else begin
         number_in = pre_neg ? (~pre_acc + 1'b1) : pre_acc;
      end
   end

   // flow control
   assign out_free        = !rsp_valid_ff || rsp_bus.ready;
   assign advance         = in_valid_ff && (!emit || out_free);
   assign req_bus.ready   = !in_valid_ff || advance;
   assign accept          = req_bus.valid && req_bus.ready;
   assign in_valid_in     = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in    = (advance && emit) ? 1'b1 :
                            (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= atoi_pkg::BASE_DEC;
         unsigned_ff  <= 1'b0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_SPACE;
         neg_ff       <= 1'b0;
         base_ff      <= atoi_pkg::BASE_AUTO;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         radix_ff     <= radix_in;
         unsigned_ff  <= unsigned_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            base_ff  <= base_in;
            acc_ff   <= acc_in;
            ovf_ff   <= ovf_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         chr_ff   <= req_bus.chr;
         first_ff <= req_bus.first;
      end
      if (advance && emit) begin
         number_ff   <= number_in;
         range_ff    <= pre_ovf;
         consumed_ff <= pre_cnt;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.number      = atoi_pkg::NUMBER_BITS'(number_ff);
   assign rsp_bus.range_error = range_ff;
   assign rsp_bus.consumed    = atoi_pkg::CONSUMED_BITS'(consumed_ff);

   // a terminating character leaves the conversion finished
   `ATOI_ASSERT_NEXT(a_done_after_result, clock, reset, advance && emit, phase_ff == PH_DONE)

   // a range error always carries one of the saturation values
   `ATOI_ASSERT_NOW(a_saturated, clock, reset, rsp_valid_ff && range_ff, number_ff == atoi_pkg::VAL_MASK || number_ff == atoi_pkg::SMAX_VAL || number_ff == atoi_pkg::SMIN_VAL)

   // the character count only grows within one conversion
   `ATOI_ASSERT_NEXT(a_count_grows, clock, reset, advance && !first_ff, cnt_ff >= $past(cnt_ff))

endmodule
